### rtl/pmcp_pkg.sv
package pmcp_pkg;

  localparam int CoordBits = 16;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam int PktBytes = 4;

  typedef enum logic [1:0] {
    OP_CMD     = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_MOVE    = 2'd3
  } op_e;

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendRate = 2'd1;
  localparam logic [1:0] PendRes  = 2'd2;

  localparam logic [7:0] AckByte      = 8'hFA;
  localparam logic [7:0] SelfTestOk   = 8'hAA;
  localparam logic [7:0] MouseId      = 8'h00;
  localparam logic [7:0] PktAlwaysOne = 8'h08;
  localparam logic [7:0] DefaultRes   = 8'h02;
  localparam logic [7:0] DefaultRate  = 8'd100;

  localparam logic [7:0] CmdReset    = 8'hFF;
  localparam logic [7:0] CmdDefaults = 8'hF6;
  localparam logic [7:0] CmdGetType  = 8'hF2;
  localparam logic [7:0] CmdStatus   = 8'hE9;
  localparam logic [7:0] CmdSetRate  = 8'hF3;
  localparam logic [7:0] CmdSetRes   = 8'hE8;
  localparam logic [7:0] CmdScale11  = 8'hE6;
  localparam logic [7:0] CmdScale21  = 8'hE7;
  localparam logic [7:0] CmdStream   = 8'hEA;
  localparam logic [7:0] CmdRemote   = 8'hF0;
  localparam logic [7:0] CmdEnable   = 8'hF4;
  localparam logic [7:0] CmdDisable  = 8'hF5;

  localparam int StScaleBit  = 4;
  localparam int StReportBit = 5;
  localparam int StRemoteBit = 6;

  typedef struct packed {
    logic [PktBytes-1:0][7:0] bytes;
    logic [1:0]               cnt_m1;
    logic                     flush;
  } resp_t;

endpackage

### rtl/pmcp_front.sv
module pmcp_front import pmcp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           cmd_byte_i,
  input  logic [2:0]           button_i,
  input  logic [CoordBits-1:0] pos_x_i,
  input  logic [CoordBits-1:0] pos_y_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output resp_t                q_entry_o
);

  logic [1:0]                  pending_q, pending_d;
  logic [7:0]                  status_q, status_d;
  logic [7:0]                  res_q, res_d;
  logic [7:0]                  rate_q, rate_d;
  logic [CoordBits-1:0]        prev_x_q, prev_x_d;
  logic [CoordBits-1:0]        prev_y_q, prev_y_d;
  logic signed [CoordBits:0]   dx_q, dx_d;
  logic signed [CoordBits:0]   dy_q, dy_d;
  logic [7:0]                  btn_q, btn_d;
  logic                        accept;
  logic                        has_resp;
  logic                        pkt_req;
  logic [7:0]                  sx, sy;
  resp_t                       entry;

  function automatic logic [7:0] sat127(input logic signed [CoordBits:0] v);
    if (v > 127) begin
      return 8'h7F;
    end else if (v < -127) begin
      return 8'h81;
    end else begin
      return v[7:0];
    end
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    pending_d = pending_q;
    status_d  = status_q;
    res_d     = res_q;
    rate_d    = rate_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    btn_d     = btn_q;
    has_resp  = 1'b0;
    pkt_req   = 1'b0;
    entry     = '0;
    entry.bytes[0] = AckByte;

    unique case (op_e'(op_i))
      OP_CMD: begin
        if (pending_q == PendRate) begin
          rate_d    = cmd_byte_i;
          pending_d = PendNone;
          has_resp  = 1'b1;
        end else if (pending_q == PendRes) begin
          res_d     = cmd_byte_i;
          pending_d = PendNone;
          has_resp  = 1'b1;
        end else if (pending_q != PendNone) begin
          pending_d = PendNone;
        end else begin
          unique case (cmd_byte_i)
            CmdReset: begin
              status_d       = '0;
              res_d          = DefaultRes;
              rate_d         = DefaultRate;
              has_resp       = 1'b1;
              entry.flush    = 1'b1;
              entry.bytes[1] = SelfTestOk;
              entry.bytes[2] = MouseId;
              entry.cnt_m1   = 2'd2;
            end
            CmdDefaults: begin
              status_d = '0;
              res_d    = DefaultRes;
              rate_d   = DefaultRate;
              has_resp = 1'b1;
            end
            CmdGetType: begin
              has_resp       = 1'b1;
              entry.bytes[1] = MouseId;
              entry.cnt_m1   = 2'd1;
            end
            CmdStatus: begin
              has_resp       = 1'b1;
              entry.bytes[1] = status_q;
              entry.bytes[2] = res_q;
              entry.bytes[3] = rate_q;
              entry.cnt_m1   = 2'd3;
            end
            CmdSetRate: begin
              pending_d = PendRate;
              has_resp  = 1'b1;
            end
            CmdSetRes: begin
              pending_d = PendRes;
              has_resp  = 1'b1;
            end
            CmdScale11: begin
              status_d[StScaleBit] = 1'b0;
              has_resp             = 1'b1;
            end
            CmdScale21: begin
              status_d[StScaleBit] = 1'b1;
              has_resp             = 1'b1;
            end
            CmdStream: begin
              status_d[StRemoteBit] = 1'b0;
              has_resp              = 1'b1;
            end
            CmdRemote: begin
              status_d[StRemoteBit] = 1'b1;
              has_resp              = 1'b1;
            end
            CmdEnable: begin
              status_d[StReportBit] = 1'b1;
              has_resp              = 1'b1;
            end
            CmdDisable: begin
              status_d[StReportBit] = 1'b0;
              has_resp              = 1'b1;
            end
            default: begin
              has_resp = 1'b0;
            end
          endcase
        end
      end
      OP_PRESS: begin
        btn_d   = btn_q | (8'd1 << button_i);
        pkt_req = 1'b1;
      end
      OP_RELEASE: begin
        btn_d   = btn_q & ~(8'd1 << button_i);
        pkt_req = 1'b1;
      end
      OP_MOVE: begin
        dx_d     = $signed({1'b0, pos_x_i}) - $signed({1'b0, prev_x_q});
        dy_d     = $signed({1'b0, pos_y_i}) - $signed({1'b0, prev_y_q});
        prev_x_d = pos_x_i;
        prev_y_d = pos_y_i;
        pkt_req  = 1'b1;
      end
      default: begin
        pkt_req = 1'b0;
      end
    endcase

    sx = sat127(dx_d);
    sy = sat127(dy_d);

    if (pkt_req && status_q[StReportBit]) begin
      has_resp       = 1'b1;
      entry.bytes[0] = PktAlwaysOne | {2'b00, dy_d[CoordBits], dx_d[CoordBits], 1'b0, btn_d[2:0]};
      entry.bytes[1] = sx;
      entry.bytes[2] = sy;
      entry.cnt_m1   = 2'd2;
      dx_d           = '0;
      dy_d           = '0;
    end
  end

  assign q_push_o  = accept && has_resp;
  assign q_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= PendNone;
      status_q  <= '0;
      res_q     <= '0;
      rate_q    <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      btn_q     <= '0;
    end else if (accept) begin
      pending_q <= pending_d;
      status_q  <= status_d;
      res_q     <= res_d;
      rate_q    <= rate_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      btn_q     <= btn_d;
    end
  end

endmodule

### rtl/pmcp_queue.sv
module pmcp_queue import pmcp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  resp_t entry_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output resp_t head_o
);

  resp_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/pmcp_back.sv
module pmcp_back import pmcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  resp_t      q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  output logic       flush_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       flush_q, flush_d;
  logic [1:0] idx_q, idx_d;
  logic       load_ok;
  logic       is_last;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign is_last = (idx_q == q_head_i.cnt_m1);

  always_comb begin
    out_valid_d = out_valid_q;
    data_d      = data_q;
    last_d      = last_q;
    flush_d     = flush_q;
    idx_d       = idx_q;
    q_pop_o     = 1'b0;
    if (load_ok) begin
      if (!q_empty_i) begin
        out_valid_d = 1'b1;
        data_d      = q_head_i.bytes[idx_q];
        last_d      = is_last;
        flush_d     = q_head_i.flush && (idx_q == 2'd0);
        if (is_last) begin
          idx_d   = 2'd0;
          q_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    last_q  <= last_d;
    flush_q <= flush_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;
  assign flush_o     = flush_q;

endmodule

### rtl/ps2_mouse_command_and_packet.sv
// Channel   Direction  Handshake              Payload
// in        to block   in_valid_i/in_stall_o   op_i, cmd_byte_i, button_i, pos_x_i, pos_y_i
// out       from block out_valid_o/out_stall_i data_byte_o, last_o, flush_o
//
// The front end accepts one request per cycle while the two-entry response queue has room.
// The back end sends one response byte per cycle while the output is not stalled, and pops a
// request's response from the queue when it loads the last byte. With the back end idle, the
// first byte of a request is written into the queue and then registered onto the output.
// Reset clears all mouse state to zero and empties the queue and the output register.
// A stall on the output backs up the queue and then stalls the input.
module ps2_mouse_command_and_packet import pmcp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           cmd_byte_i,
  input  logic [2:0]           button_i,
  input  logic [CoordBits-1:0] pos_x_i,
  input  logic [CoordBits-1:0] pos_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           data_byte_o,
  output logic                 last_o,
  output logic                 flush_o
);

  logic  q_full, q_push, q_empty, q_pop;
  resp_t q_entry, q_head;

  pmcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .cmd_byte_i (cmd_byte_i),
    .button_i   (button_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  pmcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  pmcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .flush_o     (flush_o)
  );

endmodule

### rtl/pmcp_checker.sv
module pmcp_checker import pmcp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       last_o,
  input logic       flush_o
);

  // A stalled response byte stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) && $stable(last_o)
      && $stable(flush_o))
    else $error("stalled response byte changed");

  // Only the acknowledge of a reset command carries the flush mark.
  a_flush_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_o |-> data_byte_o == AckByte && !last_o)
    else $error("flush mark on a byte other than the reset acknowledge");

  // The reset acknowledge is followed at once by the self-test byte.
  a_flush_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && flush_o |=>
      out_valid_o && data_byte_o == SelfTestOk && !flush_o && !last_o)
    else $error("reset response not followed by the self-test byte");

  // The byte after a lone acknowledge never carries the flush and final marks together.
  a_hdr_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && data_byte_o == AckByte && last_o |=>
      !(out_valid_o && flush_o && last_o))
    else $error("flush mark on a final byte");

endmodule

bind ps2_mouse_command_and_packet pmcp_checker u_pmcp_checker (.*);
